// ----- rtl/atps_pkg.sv -----
// Package for the alarm tone pattern sequencer.
// Holds event kinds, risk levels, tone timing constants and the beat structs.
// Has no dependencies; every other file of the block but atps_if imports it.
`default_nettype none

package atps_pkg;

  // Event kinds carried in the kind field. The fourth code has no meaning.
  localparam logic [1:0] KIND_UPDATE = 2'd0;
  localparam logic [1:0] KIND_CHIME  = 2'd1;
  localparam logic [1:0] KIND_STOP   = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Risk levels.
  localparam logic [1:0] LVL_SAFE     = 2'd0;
  localparam logic [1:0] LVL_MINOR    = 2'd1;
  localparam logic [1:0] LVL_HIGH     = 2'd2;
  localparam logic [1:0] LVL_CRITICAL = 2'd3;

  // Chime steps.
  localparam logic [1:0] CH_TONE_A = 2'd0;
  localparam logic [1:0] CH_GAP    = 2'd1;
  localparam logic [1:0] CH_TONE_B = 2'd2;

  // Tone frequencies in hertz.
  localparam logic [10:0] CHIME_HZ_A = 11'd1319;
  localparam logic [10:0] CHIME_HZ_B = 11'd1760;
  localparam logic [10:0] L1_HZ      = 11'd900;
  localparam logic [10:0] L2_HZ      = 11'd1100;
  localparam logic [10:0] SIREN_HZ_A = 11'd880;
  localparam logic [10:0] SIREN_HZ_B = 11'd1180;

  // Durations in milliseconds.
  localparam logic [31:0] CHIME_TONE_MS = 32'd90;
  localparam logic [31:0] CHIME_GAP_MS  = 32'd80;
  localparam logic [31:0] L1_ON_MS      = 32'd120;
  localparam logic [31:0] L1_PERIOD_MS  = 32'd5000;
  localparam logic [31:0] L1_OFF_MS     = L1_PERIOD_MS - L1_ON_MS;
  localparam logic [31:0] L2_ON_MS      = 32'd120;
  localparam logic [31:0] L2_GAP_MS     = 32'd120;
  localparam logic [31:0] L2_PAUSE_MS   = 32'd900;
  localparam logic [31:0] SIREN_STEP_MS = 32'd300;
  localparam logic [31:0] SIREN_REST_MS = 32'd3000;

  // Volume limit and its reset value.
  localparam logic [7:0] VOL_MAX   = 8'd128;
  localparam logic [7:0] VOL_RESET = 8'd128;

  // One input event.
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] now_ms;
    logic [1:0]  risk_level;
  } evt_t;

  // One buzzer result.
  typedef struct packed {
    logic        tone_on;
    logic [10:0] tone_hz;
    logic [7:0]  duty;
    logic        chime_busy;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/atps_if.sv -----
// Valid/ready channel interfaces for the alarm tone pattern sequencer.
// atps_evt_if carries input events, atps_res_if carries buzzer results.
// No dependencies.
`default_nettype none

interface atps_evt_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] now_ms;
  logic [1:0]  risk_level;

  modport source (output valid, output kind, output now_ms, output risk_level,
                  input ready);
  modport sink   (input valid, input kind, input now_ms, input risk_level,
                  output ready);
endinterface

interface atps_res_if;
  logic        valid;
  logic        ready;
  logic        tone_on;
  logic [10:0] tone_hz;
  logic [7:0]  duty;
  logic        chime_busy;

  modport source (output valid, output tone_on, output tone_hz, output duty,
                  output chime_busy, input ready);
  modport sink   (input valid, input tone_on, input tone_hz, input duty,
                  input chime_busy, output ready);
endinterface

`default_nettype wire

// ----- rtl/atps_engine.sv -----
// Sequencer state and the single-pass step logic for one event.
// Depends on atps_pkg.
`default_nettype none

module atps_engine (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           step_en,
  input  atps_pkg::evt_t      evt,
  input  wire logic [7:0]     volume,
  output atps_pkg::res_t      res
);
  import atps_pkg::*;

  logic [1:0]  last_level, last_level_next;
  logic        chime_pending, chime_pending_next;
  logic        chime_active, chime_active_next;
  logic [1:0]  chime_step, chime_step_next;
  logic [31:0] chime_start, chime_start_next;
  logic [2:0]  alarm_step, alarm_step_next;
  logic [31:0] alarm_start, alarm_start_next;
  logic        tone_sounding, tone_sounding_next;
  logic [10:0] tone_freq, tone_freq_next;
  logic [31:0] chime_el, alarm_el;
  logic        chime_own;

  // Next state for the event held in the input register.
  always_comb begin
    last_level_next    = last_level;
    chime_pending_next = chime_pending;
    chime_active_next  = chime_active;
    chime_step_next    = chime_step;
    chime_start_next   = chime_start;
    alarm_step_next    = alarm_step;
    alarm_start_next   = alarm_start;
    tone_sounding_next = tone_sounding;
    tone_freq_next     = tone_freq;
    chime_own          = 1'b0;
    chime_el           = evt.now_ms - chime_start;
    alarm_el           = 32'd0;

    unique case (evt.kind)
      KIND_UPDATE: begin
        // A level change restarts the alarm pattern silently.
        if (evt.risk_level != last_level) begin
          last_level_next    = evt.risk_level;
          alarm_step_next    = 3'd0;
          alarm_start_next   = evt.now_ms;
          tone_sounding_next = 1'b0;
        end

        // The chime, pending or running, owns the buzzer.
        chime_own = chime_pending || chime_active;
        if (chime_pending) begin
          chime_pending_next = 1'b0;
          chime_active_next  = 1'b1;
          chime_step_next    = CH_TONE_A;
          chime_start_next   = evt.now_ms;
          tone_freq_next     = CHIME_HZ_A;
          tone_sounding_next = 1'b1;
        end else if (chime_active) begin
          unique case (chime_step)
            CH_TONE_A: begin
              if (chime_el >= CHIME_TONE_MS) begin
                tone_sounding_next = 1'b0;
                chime_step_next    = CH_GAP;
                chime_start_next   = evt.now_ms;
              end
            end
            CH_GAP: begin
              if (chime_el >= CHIME_GAP_MS) begin
                tone_freq_next     = CHIME_HZ_B;
                tone_sounding_next = 1'b1;
                chime_step_next    = CH_TONE_B;
                chime_start_next   = evt.now_ms;
              end
            end
            CH_TONE_B: begin
              if (chime_el >= CHIME_TONE_MS) begin
                tone_sounding_next = 1'b0;
                chime_active_next  = 1'b0;
                chime_step_next    = CH_TONE_A;
              end
            end
            default: begin
            end
          endcase
        end

        // Alarm pattern of the current level.
        alarm_el = evt.now_ms - alarm_start_next;
        if (!chime_own) begin
          unique case (evt.risk_level)
            LVL_MINOR: begin
              unique case (alarm_step_next)
                3'd0: begin
                  tone_freq_next = L1_HZ; tone_sounding_next = 1'b1;
                  alarm_step_next = 3'd1; alarm_start_next = evt.now_ms;
                end
                3'd1: if (alarm_el >= L1_ON_MS) begin
                  tone_sounding_next = 1'b0;
                  alarm_step_next = 3'd2; alarm_start_next = evt.now_ms;
                end
                3'd2: if (alarm_el >= L1_OFF_MS) alarm_step_next = 3'd0;
                default: begin
                end
              endcase
            end
            LVL_HIGH: begin
              unique case (alarm_step_next)
                3'd0: begin
                  tone_freq_next = L2_HZ; tone_sounding_next = 1'b1;
                  alarm_step_next = 3'd1; alarm_start_next = evt.now_ms;
                end
                3'd1: if (alarm_el >= L2_ON_MS) begin
                  tone_sounding_next = 1'b0;
                  alarm_step_next = 3'd2; alarm_start_next = evt.now_ms;
                end
                3'd2: if (alarm_el >= L2_GAP_MS) begin
                  tone_freq_next = L2_HZ; tone_sounding_next = 1'b1;
                  alarm_step_next = 3'd3; alarm_start_next = evt.now_ms;
                end
                3'd3: if (alarm_el >= L2_ON_MS) begin
                  tone_sounding_next = 1'b0;
                  alarm_step_next = 3'd4; alarm_start_next = evt.now_ms;
                end
                3'd4: if (alarm_el >= L2_PAUSE_MS) alarm_step_next = 3'd0;
                default: begin
                end
              endcase
            end
            LVL_CRITICAL: begin
              unique case (alarm_step_next)
                3'd0: begin
                  tone_freq_next = SIREN_HZ_A; tone_sounding_next = 1'b1;
                  alarm_step_next = 3'd1; alarm_start_next = evt.now_ms;
                end
                3'd1: if (alarm_el >= SIREN_STEP_MS) begin
                  tone_freq_next = SIREN_HZ_B; tone_sounding_next = 1'b1;
                  alarm_step_next = 3'd2; alarm_start_next = evt.now_ms;
                end
                3'd2: if (alarm_el >= SIREN_STEP_MS) begin
                  tone_freq_next = SIREN_HZ_A; tone_sounding_next = 1'b1;
                  alarm_step_next = 3'd3; alarm_start_next = evt.now_ms;
                end
                3'd3: if (alarm_el >= SIREN_STEP_MS) begin
                  tone_freq_next = SIREN_HZ_B; tone_sounding_next = 1'b1;
                  alarm_step_next = 3'd4; alarm_start_next = evt.now_ms;
                end
                3'd4: if (alarm_el >= SIREN_STEP_MS) begin
                  tone_sounding_next = 1'b0;
                  alarm_step_next = 3'd5; alarm_start_next = evt.now_ms;
                end
                3'd5: if (alarm_el >= SIREN_REST_MS) alarm_step_next = 3'd0;
                default: begin
                end
              endcase
            end
            default: begin
            end
          endcase
        end
      end
      KIND_CHIME: begin
        chime_pending_next = 1'b1;
      end
      KIND_STOP: begin
        chime_pending_next = 1'b0;
        chime_active_next  = 1'b0;
        chime_step_next    = CH_TONE_A;
        alarm_step_next    = 3'd0;
        alarm_start_next   = evt.now_ms;
        tone_sounding_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Result seen after this event.
  always_comb begin
    res.tone_on    = tone_sounding_next;
    res.tone_hz    = tone_freq_next;
    res.duty       = tone_sounding_next ? volume : 8'd0;
    res.chime_busy = chime_pending_next || chime_active_next;
  end

  // State registers advance once per event.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_level    <= LVL_SAFE;
      chime_pending <= 1'b0;
      chime_active  <= 1'b0;
      chime_step    <= CH_TONE_A;
      chime_start   <= 32'd0;
      alarm_step    <= 3'd0;
      alarm_start   <= 32'd0;
      tone_sounding <= 1'b0;
      tone_freq     <= 11'd0;
    end else if (step_en) begin
      last_level    <= last_level_next;
      chime_pending <= chime_pending_next;
      chime_active  <= chime_active_next;
      chime_step    <= chime_step_next;
      chime_start   <= chime_start_next;
      alarm_step    <= alarm_step_next;
      alarm_start   <= alarm_start_next;
      tone_sounding <= tone_sounding_next;
      tone_freq     <= tone_freq_next;
    end
  end

`ifndef NO_ASSERTIONS
  // An idle chime always sits at its first step.
  a_chime_idle_step: assert property (@(posedge clk) disable iff (rst)
    !chime_active |-> chime_step == CH_TONE_A)
    else $error("chime step not cleared while chime idle");

  // The siren has the longest pattern; no step lies beyond it.
  a_alarm_step_range: assert property (@(posedge clk) disable iff (rst)
    alarm_step <= 3'd5)
    else $error("alarm step out of range");

  // A stop event leaves the buzzer silent and the chime idle.
  a_stop_silences: assert property (@(posedge clk) disable iff (rst)
    step_en && evt.kind == KIND_STOP |=> !tone_sounding && !chime_active && !chime_pending)
    else $error("stop event did not silence the buzzer");
`endif

endmodule

`default_nettype wire

// ----- rtl/alarm_tone_pattern_sequencer.sv -----
// Top level of the alarm tone pattern sequencer: input register, volume
// register, result register. Depends on atps_pkg, atps_if and atps_engine.
//
//   channel  direction  payload                                 interface
//   evt      in         kind, now_ms, risk_level                atps_evt_if
//   res      out        tone_on, tone_hz, duty, chime_busy      atps_res_if
//   cfg      in         volume_duty (cfg_write, cfg_data)       plain wires
//
// One event per cycle while res.ready is not held low; an accepted event shows
// its result after passing the input register and the result register.
// The step logic between the two registers is two 32-bit subtract-and-compare
// paths for the chime and alarm timers, plus selection.
// rst is synchronous; it clears both registers' valid flags and the engine state.
// A stalled result register holds its beat; the input register then fills and
// drops evt.ready.
`default_nettype none

module alarm_tone_pattern_sequencer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [7:0]  cfg_data,
  atps_evt_if.sink         evt,
  atps_res_if.source       res
);
  import atps_pkg::*;

  logic       ev_valid;
  evt_t       ev_data;
  logic       res_valid;
  res_t       res_data;
  res_t       step_res;
  logic       adv;
  logic [7:0] volume_duty;

  // The held event moves on when the result register is free or drains.
  assign adv       = ev_valid && (!res_valid || res.ready);
  assign evt.ready = !ev_valid || adv;

  // Volume register saturates at its maximum.
  always_ff @(posedge clk) begin
    if (rst) begin
      volume_duty <= VOL_RESET;
    end else if (cfg_write) begin
      volume_duty <= (cfg_data > VOL_MAX) ? VOL_MAX : cfg_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (evt.valid && evt.ready) begin
      ev_valid <= 1'b1;
    end else if (adv) begin
      ev_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.valid && evt.ready) begin
      ev_data.kind       <= evt.kind;
      ev_data.now_ms     <= evt.now_ms;
      ev_data.risk_level <= evt.risk_level;
    end
  end

  atps_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .step_en (adv),
    .evt     (ev_data),
    .volume  (volume_duty),
    .res     (step_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_data <= step_res;
    end
  end

  assign res.valid      = res_valid;
  assign res.tone_on    = res_data.tone_on;
  assign res.tone_hz    = res_data.tone_hz;
  assign res.duty       = res_data.duty;
  assign res.chime_busy = res_data.chime_busy;

`ifndef NO_ASSERTIONS
  // Every event that leaves the input register lands in the result register.
  a_adv_fills_result: assert property (@(posedge clk) disable iff (rst)
    adv |=> res_valid)
    else $error("stepped event lost before the result register");

  // Duty is zero whenever the buzzer is silent.
  a_duty_silent: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.tone_on |-> res_data.duty == 8'd0)
    else $error("duty driven while silent");

  // The volume register never exceeds its limit.
  a_volume_limit: assert property (@(posedge clk) disable iff (rst)
    volume_duty <= VOL_MAX)
    else $error("volume above limit");
`endif

endmodule

`default_nettype wire

// ----- test/buzzer_checker.sv -----
// Result checker for the alarm tone pattern sequencer testbench.
// Watches the event, result and volume ports, predicts each buzzer beat and
// compares it. Depends on atps_pkg and the atps_if channel interfaces.
`default_nettype none

module buzzer_checker
  import atps_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic [7:0] cfg_data,
  atps_evt_if             evt,
  atps_res_if             res,
  output int              fail_count,
  output int              outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // Tone plan of the buzzer, in hertz and milliseconds.
  localparam logic [10:0] CHIME_FIRST_HZ  = 11'd1319;
  localparam logic [10:0] CHIME_SECOND_HZ = 11'd1760;
  localparam logic [31:0] CHIME_TONE_LEN  = 32'd90;
  localparam logic [31:0] CHIME_GAP_LEN   = 32'd80;
  localparam logic [10:0] MINOR_HZ        = 11'd900;
  localparam logic [31:0] MINOR_ON_LEN    = 32'd120;
  localparam logic [31:0] MINOR_PERIOD    = 32'd5000;
  localparam logic [10:0] HIGH_HZ         = 11'd1100;
  localparam logic [31:0] HIGH_ON_LEN     = 32'd120;
  localparam logic [31:0] HIGH_GAP_LEN    = 32'd120;
  localparam logic [31:0] HIGH_PAUSE_LEN  = 32'd900;
  localparam logic [10:0] SIREN_LOW_HZ    = 11'd880;
  localparam logic [10:0] SIREN_HIGH_HZ   = 11'd1180;
  localparam logic [31:0] SIREN_STEP_LEN  = 32'd300;
  localparam logic [31:0] SIREN_REST_LEN  = 32'd3000;
  localparam logic [7:0]  VOLUME_CEIL     = 8'd128;
  localparam logic [7:0]  VOLUME_AT_RESET = 8'd128;

  // Mirror of the sequencer state.
  logic [7:0]  volume;
  logic [1:0]  level_seen;
  logic        chime_req;
  logic        chime_run;
  logic [1:0]  chime_phase;
  logic [31:0] chime_mark;
  logic [2:0]  pattern_step;
  logic [31:0] pattern_mark;
  logic        buzz_on;
  logic [10:0] buzz_hz;

  res_t expected_tones[$];

  function automatic void start_tone(input logic [10:0] hz);
    buzz_hz = hz;
    buzz_on = 1'b1;
  endfunction

  function automatic void move_pattern(input logic [2:0] step, input logic [31:0] t);
    pattern_step = step;
    pattern_mark = t;
  endfunction

  function automatic void restart_pattern(input logic [31:0] t);
    move_pattern(3'd0, t);
    buzz_on = 1'b0;
  endfunction

  // Runs the chime; returns 1 when the chime owns the buzzer on this tick.
  function automatic bit chime_owns(input logic [31:0] t);
    logic [31:0] since;
    since = t - chime_mark;
    if (chime_req) begin
      chime_req   = 1'b0;
      chime_run   = 1'b1;
      chime_phase = CH_TONE_A;
      chime_mark  = t;
      start_tone(CHIME_FIRST_HZ);
      return 1'b1;
    end
    if (!chime_run) return 1'b0;
    case (chime_phase)
      CH_TONE_A: begin
        if (since >= CHIME_TONE_LEN) begin
          buzz_on     = 1'b0;
          chime_phase = CH_GAP;
          chime_mark  = t;
        end
      end
      CH_GAP: begin
        if (since >= CHIME_GAP_LEN) begin
          start_tone(CHIME_SECOND_HZ);
          chime_phase = CH_TONE_B;
          chime_mark  = t;
        end
      end
      CH_TONE_B: begin
        if (since >= CHIME_TONE_LEN) begin
          buzz_on     = 1'b0;
          chime_run   = 1'b0;
          chime_phase = CH_TONE_A;
        end
      end
      default: ;
    endcase
    return 1'b1;
  endfunction

  // Advances the beep or siren pattern of the given risk level.
  function automatic void step_pattern(input logic [1:0] lvl, input logic [31:0] t);
    logic [31:0] since;
    since = t - pattern_mark;
    case (lvl)
      LVL_MINOR: begin
        case (pattern_step)
          3'd0: begin start_tone(MINOR_HZ); move_pattern(3'd1, t); end
          3'd1: if (since >= MINOR_ON_LEN) begin buzz_on = 1'b0; move_pattern(3'd2, t); end
          3'd2: if (since >= MINOR_PERIOD - MINOR_ON_LEN) pattern_step = 3'd0;
          default: ;
        endcase
      end
      LVL_HIGH: begin
        case (pattern_step)
          3'd0: begin start_tone(HIGH_HZ); move_pattern(3'd1, t); end
          3'd1: if (since >= HIGH_ON_LEN) begin buzz_on = 1'b0; move_pattern(3'd2, t); end
          3'd2: if (since >= HIGH_GAP_LEN) begin start_tone(HIGH_HZ); move_pattern(3'd3, t); end
          3'd3: if (since >= HIGH_ON_LEN) begin buzz_on = 1'b0; move_pattern(3'd4, t); end
          3'd4: if (since >= HIGH_PAUSE_LEN) pattern_step = 3'd0;
          default: ;
        endcase
      end
      LVL_CRITICAL: begin
        case (pattern_step)
          3'd0: begin start_tone(SIREN_LOW_HZ); move_pattern(3'd1, t); end
          3'd1: begin
            if (since >= SIREN_STEP_LEN) begin
              start_tone(SIREN_HIGH_HZ);
              move_pattern(3'd2, t);
            end
          end
          3'd2: begin
            if (since >= SIREN_STEP_LEN) begin
              start_tone(SIREN_LOW_HZ);
              move_pattern(3'd3, t);
            end
          end
          3'd3: begin
            if (since >= SIREN_STEP_LEN) begin
              start_tone(SIREN_HIGH_HZ);
              move_pattern(3'd4, t);
            end
          end
          3'd4: if (since >= SIREN_STEP_LEN) begin buzz_on = 1'b0; move_pattern(3'd5, t); end
          3'd5: if (since >= SIREN_REST_LEN) pattern_step = 3'd0;
          default: ;
        endcase
      end
      default: ;
    endcase
  endfunction

  // Applies one event to the mirror state and returns the buzzer beat it causes.
  function automatic res_t predict_buzzer(input evt_t e);
    res_t r;
    case (e.kind)
      KIND_UPDATE: begin
        if (e.risk_level != level_seen) begin
          level_seen = e.risk_level;
          restart_pattern(e.now_ms);
        end
        if (!chime_owns(e.now_ms)) step_pattern(e.risk_level, e.now_ms);
      end
      KIND_CHIME: chime_req = 1'b1;
      KIND_STOP: begin
        chime_req   = 1'b0;
        chime_run   = 1'b0;
        chime_phase = CH_TONE_A;
        restart_pattern(e.now_ms);
      end
      default: ;
    endcase
    r.tone_on    = buzz_on;
    r.tone_hz    = buzz_hz;
    r.duty       = buzz_on ? volume : 8'd0;
    r.chime_busy = chime_req | chime_run;
    return r;
  endfunction

  // Check each result beat against the oldest prediction, then predict the
  // beat of any event accepted on this edge.
  always @(posedge clk) begin
    evt_t seen_evt;
    res_t want;
    if (rst) begin
      volume       = VOLUME_AT_RESET;
      level_seen   = LVL_SAFE;
      chime_req    = 1'b0;
      chime_run    = 1'b0;
      chime_phase  = CH_TONE_A;
      chime_mark   = '0;
      pattern_step = 3'd0;
      pattern_mark = '0;
      buzz_on      = 1'b0;
      buzz_hz      = '0;
      expected_tones.delete();
      fail_count   = 0;
      outstanding  = 0;
    end else begin
      if (res.valid && res.ready) begin
        if (expected_tones.size() == 0) begin
          $error("result beat with no event waiting: tone_on %0d tone_hz %0d duty %0d busy %0d",
                 res.tone_on, res.tone_hz, res.duty, res.chime_busy);
          fail_count++;
        end else begin
          want = expected_tones.pop_front();
          if (res.tone_on !== want.tone_on) begin
            $error("tone_on: expected %0d, got %0d", want.tone_on, res.tone_on);
            fail_count++;
          end
          if (res.tone_hz !== want.tone_hz) begin
            $error("tone_hz: expected %0d, got %0d", want.tone_hz, res.tone_hz);
            fail_count++;
          end
          if (res.duty !== want.duty) begin
            $error("duty: expected %0d, got %0d", want.duty, res.duty);
            fail_count++;
          end
          if (res.chime_busy !== want.chime_busy) begin
            $error("chime_busy: expected %0d, got %0d", want.chime_busy, res.chime_busy);
            fail_count++;
          end
        end
      end
      if (evt.valid && evt.ready) begin
        seen_evt.kind       = evt.kind;
        seen_evt.now_ms     = evt.now_ms;
        seen_evt.risk_level = evt.risk_level;
        expected_tones.push_back(predict_buzzer(seen_evt));
      end
      // Volume writes saturate at the volume ceiling.
      if (cfg_write) volume = (cfg_data > VOLUME_CEIL) ? VOLUME_CEIL : cfg_data;
      outstanding = expected_tones.size();
    end
  end

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// Top of the alarm tone pattern sequencer testbench: clock, reset, event and
// volume stimulus, receiver stalls and the verdict. Depends on atps_pkg, the
// atps_if interfaces, buzzer_checker and the sequencer itself.
`default_nettype none

module tb;
  import atps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int EVENTS_PER_PHASE = 317;
  localparam int PHASE_COUNT      = 6;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int DRAIN_CYCLES     = 10;

  logic       clk;
  logic       rst;
  logic       cfg_write;
  logic [7:0] cfg_data;
  int         fail_count;
  int         outstanding;
  int         cycles;
  int         send_idle;
  int         recv_idle;
  int         events_sent;
  int         volume_writes;
  logic [31:0] clock_ms;
  logic [1:0]  cur_level;

  atps_evt_if evt_ch ();
  atps_res_if res_ch ();

  alarm_tone_pattern_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .evt       (evt_ch),
    .res       (res_ch)
  );

  buzzer_checker scoreboard (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .evt         (evt_ch),
    .res         (res_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // 8 ns clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run length guard.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Receiver stalls, redrawn every cycle.
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Offers one event beat and returns at the falling edge after it is taken.
  // valid stays high so back-to-back beats need no extra assignment.
  task automatic push_event(input evt_t e);
    while ($urandom_range(99) < send_idle) begin
      evt_ch.valid <= 1'b0;
      @(negedge clk);
    end
    evt_ch.valid      <= 1'b1;
    evt_ch.kind       <= e.kind;
    evt_ch.now_ms     <= e.now_ms;
    evt_ch.risk_level <= e.risk_level;
    @(posedge clk);
    while (!evt_ch.ready) @(posedge clk);
    @(negedge clk);
    events_sent++;
  endtask

  // Sends an event whose time is the running clock advanced by dt.
  task automatic send(input logic [1:0] k, input logic [31:0] dt, input logic [1:0] lvl);
    evt_t e;
    clock_ms     = clock_ms + dt;
    e.kind       = k;
    e.now_ms     = clock_ms;
    e.risk_level = lvl;
    push_event(e);
  endtask

  // Stops offering beats and waits until every result is back.
  task automatic drain();
    evt_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Volume is only written with the pipeline empty.
  task automatic set_volume(input logic [7:0] v);
    drain();
    repeat (4) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    volume_writes++;
  endtask

  // Mostly a steady stream of updates at one level with chimes and stops
  // mixed in; a few time jumps, level flips and unused kinds as noise.
  task automatic random_event(output bit counted);
    int pick;
    int unsigned dt;
    evt_t e;
    pick    = $urandom_range(99);
    counted = 1'b1;
    if ($urandom_range(99) < 70) dt = $urandom_range(150);
    else if ($urandom_range(99) < 85) dt = $urandom_range(800, 150);
    else dt = $urandom_range(6000, 800);
    if (pick < 78) begin
      if ($urandom_range(99) < 3) cur_level = 2'($urandom_range(3));
      send(KIND_UPDATE, dt, cur_level);
    end else if (pick < 86) begin
      // Time and level are don't-care on a chime request: random bits.
      e.kind       = KIND_CHIME;
      e.now_ms     = $urandom();
      e.risk_level = 2'($urandom_range(3));
      push_event(e);
    end else if (pick < 90) begin
      send(KIND_STOP, dt, 2'($urandom_range(3)));
    end else if (pick < 95) begin
      // Jump anywhere in time, including across the wrap.
      clock_ms = $urandom();
      send(KIND_UPDATE, 32'd0, 2'($urandom_range(3)));
    end else begin
      e.kind       = KIND_UNUSED;
      e.now_ms     = $urandom();
      e.risk_level = 2'($urandom_range(3));
      push_event(e);
      counted = 1'b0;
    end
  endtask

  // Stimulus.
  initial begin
    logic [7:0] volume_plan[PHASE_COUNT];
    int done;
    bit counted;
    evt_t e;

    evt_ch.valid      = 1'b0;
    evt_ch.kind       = KIND_UPDATE;
    evt_ch.now_ms     = '0;
    evt_ch.risk_level = LVL_SAFE;
    cfg_write         = 1'b0;
    cfg_data          = '0;
    rst               = 1'b1;
    send_idle         = 21;
    recv_idle         = 61;
    events_sent       = 0;
    volume_writes     = 0;
    cur_level         = LVL_SAFE;
    volume_plan       = '{8'd255, 8'd0, 8'd16, 8'd129, 8'd128, 8'd64};
    volume_plan[5]    = 8'($urandom_range(255));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset volume. The unused kind comes first with
    // every field at its top value.
    e.kind       = KIND_UNUSED;
    e.now_ms     = 32'hFFFF_FFFF;
    e.risk_level = LVL_CRITICAL;
    push_event(e);
    clock_ms = 32'd0;
    send(KIND_UPDATE, 32'd0, LVL_SAFE);
    send(KIND_CHIME, 32'd0, LVL_SAFE);
    // Chime that straddles the wrap of the millisecond clock.
    clock_ms = 32'hFFFF_FFA0;
    send(KIND_UPDATE, 32'd0, LVL_SAFE);
    send(KIND_UPDATE, 32'd89, LVL_SAFE);
    send(KIND_UPDATE, 32'd1, LVL_SAFE);
    send(KIND_UPDATE, 32'd80, LVL_SAFE);
    // Level change in the middle of the second chime tone.
    send(KIND_UPDATE, 32'd30, LVL_HIGH);
    send(KIND_UPDATE, 32'd90, LVL_HIGH);
    send(KIND_UPDATE, 32'd10, LVL_HIGH);
    send(KIND_UPDATE, 32'd120, LVL_HIGH);
    send(KIND_UPDATE, 32'd120, LVL_HIGH);
    send(KIND_STOP, 32'd20, LVL_HIGH);
    // Minor warning through one whole period.
    send(KIND_UPDATE, 32'd40, LVL_MINOR);
    send(KIND_UPDATE, 32'd120, LVL_MINOR);
    send(KIND_UPDATE, 32'd4880, LVL_MINOR);
    send(KIND_UPDATE, 32'd0, LVL_MINOR);
    // Critical siren through its rest, then a chime on top of it.
    send(KIND_UPDATE, 32'd5, LVL_CRITICAL);
    send(KIND_UPDATE, 32'd300, LVL_CRITICAL);
    send(KIND_UPDATE, 32'd300, LVL_CRITICAL);
    send(KIND_UPDATE, 32'd300, LVL_CRITICAL);
    send(KIND_UPDATE, 32'd300, LVL_CRITICAL);
    send(KIND_UPDATE, 32'd3000, LVL_CRITICAL);
    send(KIND_CHIME, 32'd0, LVL_CRITICAL);
    send(KIND_UPDATE, 32'd1, LVL_CRITICAL);
    clock_ms = 32'hFFFF_FFFE;
    send(KIND_STOP, 32'd1, LVL_SAFE);
    cur_level = LVL_CRITICAL;

    // Random phases, each at a new volume; each pair of phases shares a stall mix.
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      set_volume(volume_plan[phase]);
      case (phase / 2)
        0: begin send_idle = 21; recv_idle = 61; end
        1: begin send_idle = 61; recv_idle = 21; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      clock_ms = $urandom();
      done = 0;
      while (done < EVENTS_PER_PHASE) begin
        random_event(counted);
        if (counted) done++;
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("tb: %0d events over %0d volume settings and three stall mixes, %0d cycles",
             events_sent, volume_writes + 1, cycles);
    if (fail_count == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
